@@ rtl/assert_macros.svh @@
// assertion macros shared by the ack range retire rtl
// every use samples on clk and is disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ rtl/arsr_pkg.sv @@
// shared types, codes and widths for the ack range retire block
// no dependencies
package arsr_pkg;

	localparam int PN_W = 62;
	localparam int CODE_W = 2;
	localparam int IN_DATA_W = 192;
	localparam int OUT_DATA_W = 64;
	localparam int TABLE_SLOTS_DEF = 32;

	localparam logic [CODE_W-1:0] FUNC_RECORD = 2'd0;
	localparam logic [CODE_W-1:0] FUNC_HEADER = 2'd1;
	localparam logic [CODE_W-1:0] FUNC_PAIR = 2'd2;

	localparam logic [CODE_W-1:0] KIND_ACKED = 2'd0;
	localparam logic [CODE_W-1:0] KIND_DONE = 2'd1;
	localparam logic [CODE_W-1:0] KIND_RECORD = 2'd2;

	localparam logic [CODE_W-1:0] ST_OK = 2'd0;
	localparam logic [CODE_W-1:0] ST_FULL = 2'd1;
	localparam logic [CODE_W-1:0] ST_UNDERFLOW = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic latch_in;
		logic rec_commit;
		logic load_hdr;
		logic pair_base;
		logic gap_sub;
		logic bound_ok;
		logic scan_en;
		logic emit_done;
		logic emit_err;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
		logic pair_bad;
		logic gap_bad;
		logic len_bad;
		logic scan_end;
	} sts_t;

endpackage

@@ rtl/arsr_ctrl.sv @@
// controller state machine for the ack range retire block
// depends on arsr_pkg and assert_macros.svh
`include "assert_macros.svh"

module arsr_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic [arsr_pkg::CODE_W-1:0] func,
	output logic s_tready,
	input  arsr_pkg::sts_t sts,
	output arsr_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_REC = 4'd1;
	localparam logic [3:0] S_HDR = 4'd2;
	localparam logic [3:0] S_PAIR = 4'd3;
	localparam logic [3:0] S_GAP = 4'd4;
	localparam logic [3:0] S_BOUND = 4'd5;
	localparam logic [3:0] S_SCAN = 4'd6;
	localparam logic [3:0] S_DONE = 4'd7;
	localparam logic [3:0] S_ERR = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.latch_in = 1'b1;
					unique case (func)
						arsr_pkg::FUNC_RECORD: state_d = S_REC;
						arsr_pkg::FUNC_HEADER: state_d = S_HDR;
						arsr_pkg::FUNC_PAIR: state_d = S_PAIR;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_REC: begin
				if (sts.out_free) begin
					cmd.rec_commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_HDR: begin
				cmd.load_hdr = 1'b1;
				state_d = S_BOUND;
			end
			S_PAIR: begin
				if (sts.pair_bad) begin
					state_d = S_ERR;
				end else begin
					cmd.pair_base = 1'b1;
					state_d = S_GAP;
				end
			end
			S_GAP: begin
				if (sts.gap_bad) begin
					state_d = S_ERR;
				end else begin
					cmd.gap_sub = 1'b1;
					state_d = S_BOUND;
				end
			end
			S_BOUND: begin
				if (sts.len_bad) begin
					state_d = S_ERR;
				end else begin
					cmd.bound_ok = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_end) state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit_done = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ERR: begin
				if (sts.out_free) begin
					cmd.emit_err = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_CLK(a_one_emit, $onehot0({cmd.rec_commit, cmd.emit_done, cmd.emit_err}),
		"more than one result source in a cycle")
	`ASSERT_CLK(a_emit_needs_room, (cmd.rec_commit || cmd.emit_done || cmd.emit_err) |-> sts.out_free,
		"result issued while output register busy")
	`ASSERT_CLK(a_done_after_scan, (cmd.emit_done) |-> ($past(state_q) == S_SCAN || $past(state_q) == S_DONE),
		"done result without a scan")

endmodule

@@ rtl/arsr_dp.sv @@
// datapath: slot table, range bounds, scan pipeline and output register
// depends on arsr_pkg and assert_macros.svh
`include "assert_macros.svh"

module arsr_dp #(
	parameter int TABLE_SLOTS = arsr_pkg::TABLE_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [arsr_pkg::PN_W-1:0] in_pn,
	input  logic [arsr_pkg::PN_W-1:0] in_gap,
	input  logic [arsr_pkg::PN_W-1:0] in_len,
	input  arsr_pkg::cmd_t cmd,
	output arsr_pkg::sts_t sts,
	input  logic out_ready,
	output logic out_valid,
	output logic [arsr_pkg::CODE_W-1:0] out_kind,
	output logic [arsr_pkg::PN_W-1:0] out_pn,
	output logic [arsr_pkg::CODE_W-1:0] out_status,
	output logic out_last
);

	localparam int PW = arsr_pkg::PN_W;
	localparam int CW = arsr_pkg::CODE_W;
	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int NW = $clog2(TABLE_SLOTS + 1);

	logic [PW-1:0] pn_q, gap_q, len_q;
	logic [PW-1:0] hi_q, range_low_q;
	logic broken_q;
	logic [TABLE_SLOTS-1:0] slot_valid_q;
	logic [PW-1:0] slot_pn_q [TABLE_SLOTS];

	logic [NW-1:0] cnt_q;
	logic vld_s1;
	logic [IW-1:0] idx_s1;
	logic [PW-1:0] pn_s1;

	logic out_valid_q;
	logic [CW-1:0] out_kind_q, out_status_q;
	logic [PW-1:0] out_pn_q;
	logic out_last_q;

	logic [PW:0] base_diff, gap_diff, len_diff;
	logic free_found;
	logic [IW-1:0] free_idx;
	logic out_free, hit, adv, rd_en, cnt_end, out_load;
	logic [CW-1:0] load_kind, load_status;
	logic [PW-1:0] load_pn;
	logic load_last;

	// subtractions with borrow out in the top bit
	assign base_diff = {1'b0, range_low_q} - (PW + 1)'(2);
	assign gap_diff = {1'b0, hi_q} - {1'b0, gap_q};
	assign len_diff = {1'b0, hi_q} - {1'b0, len_q};

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (!slot_valid_q[i]) begin
				free_found = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign cnt_end = (cnt_q == NW'(TABLE_SLOTS));
	assign hit = vld_s1 && slot_valid_q[idx_s1] && (pn_s1 >= range_low_q) && (pn_s1 <= hi_q);
	assign adv = !hit || out_free;
	assign rd_en = cmd.scan_en && adv && !cnt_end;

	assign sts.out_free = out_free;
	assign sts.pair_bad = broken_q || base_diff[PW];
	assign sts.gap_bad = gap_diff[PW];
	assign sts.len_bad = len_diff[PW];
	assign sts.scan_end = cnt_end && !vld_s1;

	// request latch and range bounds
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			pn_q <= in_pn;
			gap_q <= in_gap;
			len_q <= in_len;
		end
		if (cmd.load_hdr) begin
			hi_q <= pn_q;
		end else if (cmd.pair_base) begin
			hi_q <= base_diff[PW-1:0];
		end else if (cmd.gap_sub) begin
			hi_q <= gap_diff[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q <= '0;
			broken_q <= 1'b0;
		end else begin
			if (cmd.bound_ok) range_low_q <= len_diff[PW-1:0];
			if (cmd.load_hdr) begin
				broken_q <= 1'b0;
			end else if (cmd.emit_err) begin
				broken_q <= 1'b1;
			end
		end
	end

	// slot table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.rec_commit && free_found) slot_pn_q[free_idx] <= pn_q;
		if (rd_en) pn_s1 <= slot_pn_q[cnt_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			if (cmd.rec_commit && free_found) slot_valid_q[free_idx] <= 1'b1;
			if (cmd.scan_en && hit && out_free) slot_valid_q[idx_s1] <= 1'b0;
			if (cmd.bound_ok) begin
				cnt_q <= '0;
				vld_s1 <= 1'b0;
			end else if (cmd.scan_en && adv) begin
				vld_s1 <= !cnt_end;
				if (!cnt_end) begin
					idx_s1 <= cnt_q[IW-1:0];
					cnt_q <= cnt_q + NW'(1);
				end
			end
		end
	end

	// output register
	always_comb begin
		out_load = 1'b1;
		load_kind = arsr_pkg::KIND_DONE;
		load_pn = '0;
		load_status = arsr_pkg::ST_OK;
		load_last = 1'b1;
		priority if (cmd.rec_commit) begin
			load_kind = arsr_pkg::KIND_RECORD;
			load_status = free_found ? arsr_pkg::ST_OK : arsr_pkg::ST_FULL;
		end else if (cmd.emit_err) begin
			load_status = arsr_pkg::ST_UNDERFLOW;
		end else if (cmd.emit_done) begin
			load_status = arsr_pkg::ST_OK;
		end else if (cmd.scan_en && hit && out_free) begin
			load_kind = arsr_pkg::KIND_ACKED;
			load_pn = pn_s1;
			load_last = 1'b0;
		end else begin
			out_load = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= load_kind;
			out_pn_q <= load_pn;
			out_status_q <= load_status;
			out_last_q <= load_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind = out_kind_q;
	assign out_pn = out_pn_q;
	assign out_status = out_status_q;
	assign out_last = out_last_q;

	`ASSERT_CLK(a_load_when_free, out_load |-> out_free, "output register overwritten")
	`ASSERT_CLK(a_retire_clears, (cmd.scan_en && hit && out_free) |=> !slot_valid_q[$past(idx_s1)],
		"retired slot still valid")
	`ASSERT_CLK(a_cnt_range, cnt_q <= NW'(TABLE_SLOTS), "scan counter past table end")

endmodule

@@ rtl/ack_range_sent_packet_retire.sv @@
// sent packet table with ack range retire: record, ack header and gap/range pair requests
// steps: record latch, result; header latch, bound check, table scan, done result; a pair
// adds base and gap checks before the bound check; a failed check gives an underflow result
// throughput: one request at a time, next accept after its record, done or underflow result;
// the scan reads one slot per cycle and stalls while a retired number waits on m_tready
// reset: arst_n asynchronous, clears slot valid bits, range low, broken flag, control
module ack_range_sent_packet_retire #(
	parameter int TABLE_SLOTS = arsr_pkg::TABLE_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// packet_number [61:0], gap [123:62], range_length [185:124], zero [191:186]
	input  logic [arsr_pkg::IN_DATA_W-1:0] s_tdata,
	// func [1:0]
	input  logic [arsr_pkg::CODE_W-1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// acked_pn [61:0], status [63:62]
	output logic [arsr_pkg::OUT_DATA_W-1:0] m_tdata,
	// kind [1:0]
	output logic [arsr_pkg::CODE_W-1:0] m_tuser,
	output logic m_tlast
);

	localparam int PW = arsr_pkg::PN_W;

	arsr_pkg::cmd_t cmd;
	arsr_pkg::sts_t sts;
	logic [PW-1:0] out_pn;
	logic [arsr_pkg::CODE_W-1:0] out_status;

	arsr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.func(s_tuser),
		.s_tready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	arsr_dp #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_pn(s_tdata[PW-1:0]),
		.in_gap(s_tdata[2*PW-1:PW]),
		.in_len(s_tdata[3*PW-1:2*PW]),
		.cmd(cmd),
		.sts(sts),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_kind(m_tuser),
		.out_pn(out_pn),
		.out_status(out_status),
		.out_last(m_tlast)
	);

	assign m_tdata = {out_status, out_pn};

endmodule
